/* hw/rtl/dpcf_pkg.sv */
`default_nettype none

package dpcf_pkg;

    // Fixed field widths of the request and response channels
    localparam int FUNC_W     = 2;
    localparam int CMD_DATA_W = 64;

    // Defaults for the top level parameters
    localparam int DEPTH_DEF     = 16;
    localparam int CMD_WIDTH_DEF = 64;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_PEEK  = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    // Pointer updates for one ring; at most one bit set per cycle
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

endpackage

`default_nettype wire

/* hw/rtl/dpcf_req_if.sv */
`default_nettype none

interface dpcf_req_if;
    logic                            valid;
    logic                            ready;
    logic [dpcf_pkg::FUNC_W-1:0]     func;
    logic                            prio_high;
    logic [dpcf_pkg::CMD_DATA_W-1:0] cmd_data;

    modport source (output valid, output func, output prio_high, output cmd_data,
                    input ready);
    modport sink   (input valid, input func, input prio_high, input cmd_data,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/dpcf_rsp_if.sv */
`default_nettype none

interface dpcf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [dpcf_pkg::CMD_DATA_W-1:0] cmd_out;

    modport source (output valid, output ok, output cmd_out, input ready);
    modport sink   (input valid, input ok, input cmd_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dpcf_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module dpcf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/dpcf_ring.sv */
`default_nettype none

// Write/read pointers and fill count of one ring buffer
module dpcf_ring #(
    parameter int DEPTH = dpcf_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire dpcf_pkg::t_ring_ctl      i_ctl,
    output      logic [$clog2(DEPTH)-1:0] o_wr_ptr,
    output      logic [$clog2(DEPTH)-1:0] o_rd_ptr,
    output      dpcf_pkg::t_ring_sts      o_sts
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill,   n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        priority if (i_ctl.clear) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
            n_fill   = '0;
        end else if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            n_fill   = r_fill + FILL_W'(1);
        end else if (i_ctl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            n_fill   = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    assign o_wr_ptr  = r_wr_ptr;
    assign o_rd_ptr  = r_rd_ptr;
    assign o_sts.empty = (r_fill == '0);
    assign o_sts.full  = (r_fill == FILL_FULL);

endmodule

`default_nettype wire

/* hw/rtl/dual_priority_command_fifo.sv */
`default_nettype none

// Strict-priority pair of command FIFOs, each DEPTH entries of CMD_WIDTH bits.
// Request channel i_req: func (push, pop, peek, clear), prio_high (queue
// chosen by push and clear) and cmd_data (low CMD_WIDTH bits kept by push).
// Response channel o_rsp: one response per request, ok and cmd_out (zero
// unless a pop or peek succeeded; zero-extended above CMD_WIDTH).
// Pop and peek serve the high queue first, then the low queue.
// Push, clear and a pop or peek that finds both queues empty respond
// the cycle after acceptance; a pop or peek that finds an entry passes through
// the READ state, as the entry is read from a RAM with a registered output.
// Throughput: one push/clear/failed read per cycle while the sink takes
// responses; a served pop/peek holds off new requests during its RAM read
// (READ state), so no new request is taken before it is through.
// The response sits in an output register. A new request is taken while a
// response waits, as long as the sink takes it in the same cycle; while the
// sink stalls, ready stays low and the pending response holds.
// Reset (synchronous, active low) empties both queues and drops any pending
// response; RAM contents are left alone and need no clearing pass.
module dual_priority_command_fifo #(
    parameter int DEPTH     = dpcf_pkg::DEPTH_DEF,
    parameter int CMD_WIDTH = dpcf_pkg::CMD_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dpcf_req_if.sink     i_req,
    dpcf_rsp_if.source   o_rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OUT_W = dpcf_pkg::CMD_DATA_W;

    dpcf_pkg::t_state    r_state, n_state;
    logic                r_sel_high;
    logic                r_out_valid, n_out_valid;
    logic                r_ok,        n_ok;
    logic [OUT_W-1:0]    r_cmd,       n_cmd;

    dpcf_pkg::t_ring_ctl hi_ctl, lo_ctl;
    dpcf_pkg::t_ring_sts hi_sts, lo_sts;
    logic [PTR_W-1:0]    hi_wr_ptr, hi_rd_ptr, lo_wr_ptr, lo_rd_ptr;
    logic [CMD_WIDTH-1:0] hi_rdata, lo_rdata, wdata;

    logic accept, is_push, is_pop, is_peek, is_clear, hp;
    logic rd_req, tgt_full;

    dpcf_pkg::t_func func;

    assign func = dpcf_pkg::t_func'(i_req.func);
    assign hp   = i_req.prio_high;

    // Take a request only when idle and the response register is free or
    // being emptied in this cycle.
    assign i_req.ready = (r_state == dpcf_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    assign is_push  = (func == dpcf_pkg::FN_PUSH);
    assign is_pop   = (func == dpcf_pkg::FN_POP);
    assign is_peek  = (func == dpcf_pkg::FN_PEEK);
    assign is_clear = (func == dpcf_pkg::FN_CLEAR);

    assign tgt_full = hp ? hi_sts.full : lo_sts.full;
    // Pop or peek that finds something to serve
    assign rd_req   = accept && (is_pop || is_peek) && !(hi_sts.empty && lo_sts.empty);

    assign wdata = i_req.cmd_data[CMD_WIDTH-1:0];

    always_comb begin
        hi_ctl.push  = accept && is_push && hp && !hi_sts.full;
        hi_ctl.pop   = accept && is_pop && !hi_sts.empty;
        hi_ctl.clear = accept && is_clear && hp;
        lo_ctl.push  = accept && is_push && !hp && !lo_sts.full;
        lo_ctl.pop   = accept && is_pop && hi_sts.empty && !lo_sts.empty;
        lo_ctl.clear = accept && is_clear && !hp;
    end

    dpcf_ring #(.DEPTH(DEPTH)) u_hi_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (hi_ctl),
        .o_wr_ptr (hi_wr_ptr),
        .o_rd_ptr (hi_rd_ptr),
        .o_sts    (hi_sts)
    );

    dpcf_ring #(.DEPTH(DEPTH)) u_lo_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lo_ctl),
        .o_wr_ptr (lo_wr_ptr),
        .o_rd_ptr (lo_rd_ptr),
        .o_sts    (lo_sts)
    );

    // Requests are handled one at a time, so a write always lands before
    // any later read of the same entry: no forwarding needed.
    dpcf_ram #(.WIDTH(CMD_WIDTH), .DEPTH(DEPTH)) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (hi_ctl.push),
        .i_waddr (hi_wr_ptr),
        .i_wdata (wdata),
        .i_re    (rd_req && !hi_sts.empty),
        .i_raddr (hi_rd_ptr),
        .o_rdata (hi_rdata)
    );

    dpcf_ram #(.WIDTH(CMD_WIDTH), .DEPTH(DEPTH)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (lo_ctl.push),
        .i_waddr (lo_wr_ptr),
        .i_wdata (wdata),
        .i_re    (rd_req && hi_sts.empty),
        .i_raddr (lo_rd_ptr),
        .o_rdata (lo_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dpcf_pkg::ST_IDLE: if (rd_req) n_state = dpcf_pkg::ST_READ;
            dpcf_pkg::ST_READ: n_state = dpcf_pkg::ST_IDLE;
            default:           n_state = dpcf_pkg::ST_IDLE;
        endcase
    end

    // Response register
    always_comb begin
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_ok        = r_ok;
        n_cmd       = r_cmd;
        unique case (r_state)
            dpcf_pkg::ST_IDLE: begin
                if (accept && !rd_req) begin
                    n_out_valid = 1'b1;
                    n_ok        = (is_push && !tgt_full) || is_clear;
                    n_cmd       = '0;
                end
            end
            dpcf_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_ok        = 1'b1;
                n_cmd       = OUT_W'(r_sel_high ? hi_rdata : lo_rdata);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpcf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok  <= n_ok;
        r_cmd <= n_cmd;
        if (rd_req) begin
            r_sel_high <= !hi_sts.empty;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.ok      = r_ok;
    assign o_rsp.cmd_out = r_cmd;

endmodule

`default_nettype wire

/* hw/rtl/dpcf_checker.sv */
`default_nettype none

module dpcf_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_req_valid,
    input wire logic                            i_req_ready,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic                            i_rsp_ok,
    input wire logic [dpcf_pkg::CMD_DATA_W-1:0] i_rsp_cmd_out
);

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_ok) && $stable(i_rsp_cmd_out))
        else $error("stalled response changed");

    // No response straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A failed request never returns a command
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> i_rsp_cmd_out == '0)
        else $error("failed response carries a command");

    // No request taken while a response is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> !i_rsp_valid || i_rsp_ready)
        else $error("request accepted over a stalled response");

endmodule

bind dual_priority_command_fifo dpcf_checker u_dpcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_ok      (o_rsp.ok),
    .i_rsp_cmd_out (o_rsp.cmd_out)
);

`default_nettype wire
